// ===== design/dmc_pkg.sv =====
// Shared constants, codes and helper functions for the maze carver.
`default_nettype none

package dmc_pkg;

    // Default grid limits handed to the top level.
    localparam int MAX_WIDTH_DEF  = 32;
    localparam int MAX_HEIGHT_DEF = 32;

    // Field widths of the channels and the configuration port.
    localparam int RAND_W     = 15;
    localparam int COORD_W    = 5;
    localparam int DIR_W      = 2;
    localparam int DIM_W      = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_X     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_Y     = 2'd3;

    // Register reset values.
    localparam logic [DIM_W-1:0]   GRID_DIM_RESET = 6'd32;
    localparam logic [COORD_W-1:0] START_RESET    = 5'd0;

    // Operation codes.
    localparam logic OP_START = 1'b0;
    localparam logic OP_CARVE = 1'b1;

    // Direction codes, checked in this order.
    localparam logic [DIR_W-1:0] DIR_UP    = 2'd0;
    localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd1;
    localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd2;
    localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd3;

    // Residue of the random word modulo 3 by folding base-4 digits.
    function automatic logic [1:0] mod3(input logic [RAND_W-1:0] v);
        logic [4:0] s;
        logic [2:0] f;
        logic [1:0] r;
        s = {4'd0, v[14]};
        for (int i = 0; i < 7; i++)
        begin
            s = s + {3'd0, v[2*i +: 2]};
        end
        f = {1'b0, s[1:0]} + {1'b0, s[3:2]} + {2'd0, s[4]};
        if (f >= 3'd6)
        begin
            r = 2'(f - 3'd6);
        end
        else if (f >= 3'd3)
        begin
            r = 2'(f - 3'd3);
        end
        else
        begin
            r = f[1:0];
        end
        return r;
    endfunction

    // Take candidate number (random mod count) among the set direction bits.
    function automatic logic [DIR_W-1:0] pick_dir(
        input logic [3:0]        cand,
        input logic [RAND_W-1:0] rnd,
        input logic [1:0]        rmod3
    );
        logic [2:0]       n;
        logic [1:0]       k;
        logic [2:0]       seen;
        logic [DIR_W-1:0] dir;
        n    = 3'($countones(cand));
        seen = 3'd0;
        dir  = DIR_UP;
        case (n)
            3'd2:    k = {1'b0, rnd[0]};
            3'd3:    k = rmod3;
            3'd4:    k = rnd[1:0];
            default: k = 2'd0;
        endcase
        for (int d = 0; d < 4; d++)
        begin
            if (cand[d] && (seen == {1'b0, k}))
            begin
                dir = DIR_W'(d);
            end
            if (cand[d])
            begin
                seen = seen + 3'd1;
            end
        end
        return dir;
    endfunction

endpackage

`default_nettype wire

// ===== design/dmc_if.sv =====
// Valid/ready channel interfaces for the item and result beats.
`default_nettype none

interface dmc_item_if import dmc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              op;
    logic [RAND_W-1:0] random_word;

    modport source (output valid, op, random_word, input ready);
    modport sink   (input valid, op, random_word, output ready);
endinterface

interface dmc_result_if import dmc_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               carved;
    logic [COORD_W-1:0] from_x;
    logic [COORD_W-1:0] from_y;
    logic [DIR_W-1:0]   direction;
    logic               finished;

    modport source (output valid, carved, from_x, from_y, direction, finished, input ready);
    modport sink   (input valid, carved, from_x, from_y, direction, finished, output ready);
endinterface

`default_nettype wire

// ===== design/dmc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module dmc_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== design/dfs_maze_carver_core.sv =====
// Flow: a carve beat runs the neighbor scan and the pick, plus a pop wait and a new scan per dead-end cell popped.
// Each stack-top cell costs 4 visited-map reads through one read port plus a pick state.
// A start beat sweeps the visited map, all 2^(log2 MAX_WIDTH + log2 MAX_HEIGHT) entries (1024).
// Throughput: one beat at a time; the next beat enters once the result is in the output reg.
// Reset: async active-low; clears stack depth, visited count, control and config registers.
// Carve beats before the first start return carved 0; the visited map needs no reset sweep.
`default_nettype none

module dfs_maze_carver_core import dmc_pkg::*; #(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    dmc_item_if.sink                   item,
    dmc_result_if.source               result,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    // Cell coordinates and packed {y, x} cell address.
    localparam int XW         = $clog2(MAX_WIDTH);
    localparam int YW         = $clog2(MAX_HEIGHT);
    localparam int AW         = XW + YW;
    localparam int VIS_DEPTH  = 1 << AW;
    // Stack holds at most every cell once.
    localparam int CELL_COUNT = MAX_WIDTH * MAX_HEIGHT;
    localparam int SAW        = $clog2(CELL_COUNT);
    localparam int DW         = $clog2(CELL_COUNT + 1);
    // Width and height in use, and their product.
    localparam int WW         = $clog2(MAX_WIDTH + 1);
    localparam int HW         = $clog2(MAX_HEIGHT + 1);
    localparam int CNW        = WW + HW;

    // Sequencer states.
    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_CLEAR   = 3'd1;
    localparam logic [2:0] ST_NBR     = 3'd2;
    localparam logic [2:0] ST_PICK    = 3'd3;
    localparam logic [2:0] ST_POPWAIT = 3'd4;
    localparam logic [2:0] ST_EMIT    = 3'd5;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [DIM_W-1:0]   grid_width_reg;
    logic [DIM_W-1:0]   grid_height_reg;
    logic [COORD_W-1:0] start_x_reg;
    logic [COORD_W-1:0] start_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= GRID_DIM_RESET;
            grid_height_reg <= GRID_DIM_RESET;
            start_x_reg     <= START_RESET;
            start_y_reg     <= START_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_GRID_WIDTH:  grid_width_reg  <= cfg_data;
                CFG_GRID_HEIGHT: grid_height_reg <= cfg_data;
                CFG_START_X:     start_x_reg     <= cfg_data[COORD_W-1:0];
                CFG_START_Y:     start_y_reg     <= cfg_data[COORD_W-1:0];
            endcase
        end
    end

    // Saturate the size: zero counts as one, above the maximum as the maximum.
    logic [WW-1:0]  width_used;
    logic [HW-1:0]  height_used;
    logic [CNW-1:0] cells_used;
    logic [XW-1:0]  start_xs;
    logic [YW-1:0]  start_ys;

    always_comb
    begin
        if (grid_width_reg == '0)
        begin
            width_used = WW'(1);
        end
        else if (32'(grid_width_reg) > MAX_WIDTH)
        begin
            width_used = WW'(MAX_WIDTH);
        end
        else
        begin
            width_used = WW'(grid_width_reg);
        end

        if (grid_height_reg == '0)
        begin
            height_used = HW'(1);
        end
        else if (32'(grid_height_reg) > MAX_HEIGHT)
        begin
            height_used = HW'(MAX_HEIGHT);
        end
        else
        begin
            height_used = HW'(grid_height_reg);
        end

        cells_used = CNW'(width_used) * CNW'(height_used);

        // Clamp the start cell to the last column and row in use.
        if (32'(start_x_reg) >= 32'(width_used))
        begin
            start_xs = XW'(width_used - WW'(1));
        end
        else
        begin
            start_xs = XW'(start_x_reg);
        end

        if (32'(start_y_reg) >= 32'(height_used))
        begin
            start_ys = YW'(height_used - HW'(1));
        end
        else
        begin
            start_ys = YW'(start_y_reg);
        end
    end

    // ------------------------------------------------------------------
    // Neighbor helpers
    // ------------------------------------------------------------------
    function automatic logic nbr_inside(
        input logic [DIR_W-1:0] d,
        input logic [AW-1:0]    c,
        input logic [WW-1:0]    wu,
        input logic [HW-1:0]    hu
    );
        logic          ok;
        logic [XW-1:0] x;
        logic [YW-1:0] y;
        x = c[XW-1:0];
        y = c[AW-1:XW];
        unique case (d)
            DIR_UP:    ok = (y != '0);
            DIR_RIGHT: ok = (32'(x) + 32'd1) < 32'(wu);
            DIR_DOWN:  ok = (32'(y) + 32'd1) < 32'(hu);
            DIR_LEFT:  ok = (x != '0);
        endcase
        return ok;
    endfunction

    function automatic logic [AW-1:0] nbr_cell(
        input logic [DIR_W-1:0] d,
        input logic [AW-1:0]    c
    );
        logic [AW-1:0] n;
        logic [XW-1:0] x;
        logic [YW-1:0] y;
        x = c[XW-1:0];
        y = c[AW-1:XW];
        unique case (d)
            DIR_UP:    n = {YW'(y - YW'(1)), x};
            DIR_RIGHT: n = {y, XW'(x + XW'(1))};
            DIR_DOWN:  n = {YW'(y + YW'(1)), x};
            DIR_LEFT:  n = {y, XW'(x - XW'(1))};
        endcase
        return n;
    endfunction

    // ------------------------------------------------------------------
    // Memories: visited map (1 bit per cell) and cell stack
    // ------------------------------------------------------------------
    logic                vis_we;
    logic [AW-1:0]       vis_waddr;
    logic                vis_wdata;
    logic [AW-1:0]       vis_raddr;
    logic                vis_rdata;

    logic                stk_we;
    logic [SAW-1:0]      stk_waddr;
    logic [AW-1:0]       stk_wdata;
    logic [SAW-1:0]      stk_raddr;
    logic [AW-1:0]       stk_rdata;

    dmc_ram #(
        .WIDTH (1),
        .DEPTH (VIS_DEPTH)
    ) u_visited (
        .clk   (clk),
        .we    (vis_we),
        .waddr (vis_waddr),
        .wdata (vis_wdata),
        .raddr (vis_raddr),
        .rdata (vis_rdata)
    );

    dmc_ram #(
        .WIDTH (AW),
        .DEPTH (CELL_COUNT)
    ) u_stack (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    // ------------------------------------------------------------------
    // Sequencer registers
    // ------------------------------------------------------------------
    logic [2:0]         state_reg,   state_next;
    logic [AW-1:0]      top_reg,     top_next;
    logic [DW-1:0]      depth_reg,   depth_next;
    logic [DW-1:0]      count_reg,   count_next;
    logic [2:0]         cnt_reg,     cnt_next;
    logic               live_reg,    live_next;
    logic [3:0]         cand_reg,    cand_next;
    logic [AW-1:0]      clr_reg,     clr_next;

    // Payload registers: no reset.
    logic [RAND_W-1:0]  rnd_reg;
    logic [1:0]         rmod3_reg;
    logic [AW-1:0]      start_cell_reg, start_cell_next;
    logic               res_carved_reg, res_carved_next;
    logic [COORD_W-1:0] res_x_reg,      res_x_next;
    logic [COORD_W-1:0] res_y_reg,      res_y_next;
    logic [DIR_W-1:0]   res_dir_reg,    res_dir_next;

    // Output register.
    logic               out_valid_reg,  out_valid_next;
    logic               out_carved_reg;
    logic [COORD_W-1:0] out_x_reg;
    logic [COORD_W-1:0] out_y_reg;
    logic [DIR_W-1:0]   out_dir_reg;
    logic               out_finished_reg;

    logic               item_accept;
    logic               out_load;
    logic               maze_done;
    logic [DIR_W-1:0]   scan_dir;
    logic [DIR_W-1:0]   pick;
    logic [AW-1:0]      pick_cell;
    logic [1:0]         cand_idx;

    assign item.ready  = (state_reg == ST_IDLE);
    assign item_accept = item.valid && item.ready;
    assign maze_done   = 32'(count_reg) >= 32'(cells_used);
    assign scan_dir    = cnt_reg[DIR_W-1:0];
    // Result of the read issued in the previous cycle; wraps to the last direction.
    assign cand_idx    = 2'(cnt_reg[1:0] - 2'd1);
    assign pick        = pick_dir(cand_reg, rnd_reg, rmod3_reg);
    assign pick_cell   = nbr_cell(pick, top_reg);
    assign out_load    = (state_reg == ST_EMIT) && (!out_valid_reg || result.ready);

    always_comb
    begin
        state_next      = state_reg;
        top_next        = top_reg;
        depth_next      = depth_reg;
        count_next      = count_reg;
        cnt_next        = cnt_reg;
        live_next       = live_reg;
        cand_next       = cand_reg;
        clr_next        = clr_reg;
        start_cell_next = start_cell_reg;
        res_carved_next = res_carved_reg;
        res_x_next      = res_x_reg;
        res_y_next      = res_y_reg;
        res_dir_next    = res_dir_reg;

        vis_we    = 1'b0;
        vis_waddr = clr_reg;
        vis_wdata = 1'b0;
        vis_raddr = nbr_cell(scan_dir, top_reg);
        stk_we    = 1'b0;
        stk_waddr = depth_reg[SAW-1:0];
        stk_wdata = pick_cell;
        // New stack top after a pop lives one entry below the current top.
        stk_raddr = SAW'(depth_reg - DW'(2));

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_accept)
                begin
                    res_carved_next = 1'b0;
                    res_x_next      = '0;
                    res_y_next      = '0;
                    res_dir_next    = DIR_UP;
                    if (item.op == OP_START)
                    begin
                        start_cell_next = {start_ys, start_xs};
                        clr_next        = '0;
                        state_next      = ST_CLEAR;
                    end
                    else if (maze_done || (depth_reg == '0))
                    begin
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        cnt_next   = '0;
                        state_next = ST_NBR;
                    end
                end
            end

            ST_CLEAR:
            begin
                // Sweep the map; the start cell is written as visited in passing.
                vis_we    = 1'b1;
                vis_waddr = clr_reg;
                vis_wdata = (clr_reg == start_cell_reg);
                clr_next  = AW'(clr_reg + AW'(1));
                if (&clr_reg)
                begin
                    stk_we     = 1'b1;
                    stk_waddr  = '0;
                    stk_wdata  = start_cell_reg;
                    top_next   = start_cell_reg;
                    depth_next = DW'(1);
                    count_next = DW'(1);
                    state_next = ST_EMIT;
                end
            end

            ST_NBR:
            begin
                // Issue one neighbor read per cycle, collect it the cycle after.
                live_next = nbr_inside(scan_dir, top_reg, width_used, height_used);
                if (cnt_reg != '0)
                begin
                    cand_next[cand_idx] = live_reg && !vis_rdata;
                end
                cnt_next = 3'(cnt_reg + 3'd1);
                if (cnt_reg == 3'd4)
                begin
                    state_next = ST_PICK;
                end
            end

            ST_PICK:
            begin
                if (cand_reg == '0)
                begin
                    // Dead end: drop the top cell.
                    depth_next = DW'(depth_reg - DW'(1));
                    if (depth_reg == DW'(1))
                    begin
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        state_next = ST_POPWAIT;
                    end
                end
                else
                begin
                    vis_we    = 1'b1;
                    vis_waddr = pick_cell;
                    vis_wdata = 1'b1;
                    if (32'(depth_reg) < CELL_COUNT)
                    begin
                        stk_we     = 1'b1;
                        depth_next = DW'(depth_reg + DW'(1));
                    end
                    top_next        = pick_cell;
                    count_next      = DW'(count_reg + DW'(1));
                    res_carved_next = 1'b1;
                    res_x_next      = COORD_W'(top_reg[XW-1:0]);
                    res_y_next      = COORD_W'(top_reg[AW-1:XW]);
                    res_dir_next    = pick;
                    state_next      = ST_EMIT;
                end
            end

            ST_POPWAIT:
            begin
                top_next   = stk_rdata;
                cnt_next   = '0;
                state_next = ST_NBR;
            end

            ST_EMIT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output valid: set on load, drop once the beat is taken.
    always_comb
    begin
        out_valid_next = out_valid_reg && !result.ready;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            top_reg       <= '0;
            depth_reg     <= '0;
            count_reg     <= '0;
            cnt_reg       <= '0;
            live_reg      <= 1'b0;
            cand_reg      <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            top_reg       <= top_next;
            depth_reg     <= depth_next;
            count_reg     <= count_next;
            cnt_reg       <= cnt_next;
            live_reg      <= live_next;
            cand_reg      <= cand_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_accept)
        begin
            rnd_reg   <= item.random_word;
            rmod3_reg <= mod3(item.random_word);
        end
        start_cell_reg <= start_cell_next;
        res_carved_reg <= res_carved_next;
        res_x_reg      <= res_x_next;
        res_y_reg      <= res_y_next;
        res_dir_reg    <= res_dir_next;
        if (out_load)
        begin
            out_carved_reg   <= res_carved_reg;
            out_x_reg        <= res_x_reg;
            out_y_reg        <= res_y_reg;
            out_dir_reg      <= res_dir_reg;
            out_finished_reg <= maze_done;
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.carved    = out_carved_reg;
    assign result.from_x    = out_x_reg;
    assign result.from_y    = out_y_reg;
    assign result.direction = out_dir_reg;
    assign result.finished  = out_finished_reg;

endmodule

`default_nettype wire

// ===== design/dmc_checker.sv =====
// Port-level assertions for the maze carver, bound to the top level.
`default_nettype none

module dmc_checker import dmc_pkg::*; (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               item_valid,
    input wire logic               item_ready,
    input wire logic               res_valid,
    input wire logic               res_ready,
    input wire logic               res_carved,
    input wire logic [COORD_W-1:0] res_from_x,
    input wire logic [COORD_W-1:0] res_from_y,
    input wire logic [DIR_W-1:0]   res_direction,
    input wire logic               res_finished
);

    // A stalled result beat stays valid.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> res_valid)
        else $error("result valid dropped while stalled");

    // A stalled result beat keeps its payload.
    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> ($stable(res_carved) && $stable(res_from_x)
            && $stable(res_from_y) && $stable(res_direction) && $stable(res_finished)))
        else $error("result payload changed while stalled");

    // No passage: coordinates and direction read zero.
    a_no_carve_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_carved) |-> ((res_from_x == '0) && (res_from_y == '0)
            && (res_direction == DIR_UP)))
        else $error("non-carved result carries passage fields");

    // One beat in work at a time: ready drops right after an accept.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item_ready) |=> !item_ready)
        else $error("item accepted while previous beat in work");

endmodule

bind dfs_maze_carver_core dmc_checker u_dmc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .item_valid    (item.valid),
    .item_ready    (item.ready),
    .res_valid     (result.valid),
    .res_ready     (result.ready),
    .res_carved    (result.carved),
    .res_from_x    (result.from_x),
    .res_from_y    (result.from_y),
    .res_direction (result.direction),
    .res_finished  (result.finished)
);

`default_nettype wire
